// ----- src/pps_pkg.sv -----
`default_nettype none

package pps_pkg;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [3:0]  slot;
		logic [7:0]  burst_length;
		logic [15:0] arrival_time;
		logic [7:0]  priority_level;
	} item_t;

	typedef struct packed {
		logic        ran;
		logic [3:0]  ran_slot;
		logic [15:0] start_time;
		logic        finished;
		logic [15:0] waiting_time;
		logic [15:0] turnaround_time;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

endpackage

`default_nettype wire

// ----- src/preemptive_priority_scheduler_core.sv -----
`default_nettype none

// Channel   Ports                      Beat taken when
// -------   -------------------------  ------------------------------
// command   start, busy, item          rising edge with start & !busy
// result    done, result               rising edge ending the done cycle
//
// A load command is written to the slot table at its accepting edge; busy
// stays low and no result beat follows.
// A tick command runs a scan, then an update: one comparator walks the slot
// table through a single registered read port, one entry per cycle, then
// the update state writes back the winner and registers the result beat.
// done is high for one cycle after the update; a new command may be
// accepted in that same cycle.
// arst_n clears the active bits, current time and the sequencer; the slot
// table itself is not cleared, entries are read only behind an active bit.
// The receiver cannot stall: each result beat is shown once and is gone.

module preemptive_priority_scheduler_core #(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  pps_pkg::item_t  item,
	output logic            done,
	output pps_pkg::result_t result
);

	import pps_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// slot table: one write port (load or update), one registered read port (scan)
	logic [7:0]           mem_burst [SLOTS];
	logic [7:0]           mem_rem   [SLOTS];
	logic [TIME_BITS-1:0] mem_arr   [SLOTS];
	logic [7:0]           mem_pri   [SLOTS];

	logic [SLOTS-1:0]     active_q;
	logic [TIME_BITS-1:0] time_q;
	state_t               state_q, state_nxt;
	logic [CNT_W-1:0]     ptr_q;

	// read pipeline
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [7:0]           rd_burst_s1;
	logic [7:0]           rd_rem_s1;
	logic [TIME_BITS-1:0] rd_arr_s1;
	logic [7:0]           rd_pri_s1;

	// best candidate so far
	logic                 best_vld_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [7:0]           best_burst_q;
	logic [7:0]           best_rem_q;
	logic [TIME_BITS-1:0] best_arr_q;
	logic [7:0]           best_pri_q;

	logic                 done_q;
	result_t              result_q;

	logic                 accept;
	logic                 load_we;
	logic [IDX_W-1:0]     load_idx;
	logic                 issue_rd;
	logic                 elig;
	logic                 better;
	logic [7:0]           rem_new;
	logic [TIME_BITS-1:0] fin_time;
	logic [TIME_BITS-1:0] tat;
	logic [TIME_BITS-1:0] wt;

	assign accept   = start && !busy;
	assign load_idx = IDX_W'(item.slot);
	// loads past the end of the table are dropped
	assign load_we  = accept && (item.operation == OP_LOAD) && (32'(item.slot) < SLOTS);

	assign issue_rd = (state_q == ST_SCAN) && (ptr_q < CNT_W'(SLOTS));

	// readiness: loaded, unfinished and arrived; then priority, then arrival.
	// Scan order is ascending, so equal keys keep the lower slot.
	assign elig   = rd_vld_s1 && active_q[rd_idx_s1] && (rd_rem_s1 != 8'd0)
	                && (rd_arr_s1 <= time_q);
	assign better = !best_vld_q || (rd_pri_s1 < best_pri_q)
	                || ((rd_pri_s1 == best_pri_q) && (rd_arr_s1 < best_arr_q));

	assign rem_new  = best_rem_q - 8'd1;
	assign fin_time = time_q + TIME_BITS'(1);
	assign tat      = fin_time - best_arr_q;
	assign wt       = tat - TIME_BITS'(best_burst_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		busy      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && item.operation == OP_TICK) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// last compare happens in the cycle after the last read
				if (ptr_q == CNT_W'(SLOTS)) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			time_q     <= '0;
			ptr_q      <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue_rd;
			if (load_we) begin
				active_q[load_idx] <= 1'b1;
			end
			if (accept && item.operation == OP_TICK) begin
				ptr_q      <= '0;
				best_vld_q <= 1'b0;
			end
			if (issue_rd) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (state_q == ST_SCAN && elig && better) begin
				best_vld_q <= 1'b1;
			end
			if (state_q == ST_UPDATE) begin
				// idle ticks advance time as well
				time_q <= fin_time;
				done_q <= 1'b1;
			end
		end
	end

	// slot table write and registered read
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem_burst[load_idx] <= item.burst_length;
			mem_rem[load_idx]   <= item.burst_length;
			mem_arr[load_idx]   <= TIME_BITS'(item.arrival_time);
			mem_pri[load_idx]   <= item.priority_level;
		end else if (state_q == ST_UPDATE && best_vld_q) begin
			mem_rem[best_idx_q] <= rem_new;
		end
		if (issue_rd) begin
			rd_burst_s1 <= mem_burst[ptr_q[IDX_W-1:0]];
			rd_rem_s1   <= mem_rem[ptr_q[IDX_W-1:0]];
			rd_arr_s1   <= mem_arr[ptr_q[IDX_W-1:0]];
			rd_pri_s1   <= mem_pri[ptr_q[IDX_W-1:0]];
			rd_idx_s1   <= ptr_q[IDX_W-1:0];
		end
	end

	// winner payload and result beat
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && elig && better) begin
			best_idx_q   <= rd_idx_s1;
			best_burst_q <= rd_burst_s1;
			best_rem_q   <= rd_rem_s1;
			best_arr_q   <= rd_arr_s1;
			best_pri_q   <= rd_pri_s1;
		end
		if (state_q == ST_UPDATE) begin
			result_q.start_time <= 16'(time_q);
			if (best_vld_q) begin
				result_q.ran      <= 1'b1;
				result_q.ran_slot <= 4'(best_idx_q);
				if (rem_new == 8'd0) begin
					result_q.finished        <= 1'b1;
					result_q.waiting_time    <= 16'(wt);
					result_q.turnaround_time <= 16'(tat);
				end else begin
					result_q.finished        <= 1'b0;
					result_q.waiting_time    <= 16'd0;
					result_q.turnaround_time <= 16'd0;
				end
			end else begin
				result_q.ran             <= 1'b0;
				result_q.ran_slot        <= 4'd0;
				result_q.finished        <= 1'b0;
				result_q.waiting_time    <= 16'd0;
				result_q.turnaround_time <= 16'd0;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a result beat only ever follows the update cycle
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE))
		else $error("result beat without update cycle");

	// an idle tick reports no completion
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.ran) |-> (!result.finished && result.waiting_time == 16'd0
		&& result.turnaround_time == 16'd0))
		else $error("idle tick reports completion");

	// a tick makes the block busy; a load does not
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == OP_TICK) |=> busy)
		else $error("tick accepted but block not busy");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == OP_LOAD) |=> (!busy && !done))
		else $error("load produced activity");

endmodule

`default_nettype wire
